>>> design/assert_macros.svh
// Assertion helpers for the RTL files that carry checks.
// Every check is clocked on clk and is switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds on every clock edge outside reset.
`define BBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds on the same edge.
`define BBC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds on the next edge.
`define BBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Types and constants shared by the bracket balance checker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

	localparam logic [15:0] POS_MAX = 16'hFFFF;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LSQUARE = 8'h5B;
	localparam logic [7:0] CH_RSQUARE = 8'h5D;
	localparam logic [7:0] CH_LCURLY = 8'h7B;
	localparam logic [7:0] CH_RCURLY = 8'h7D;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	localparam logic OP_TEXT = 1'b0;
	localparam logic OP_END = 1'b1;

	typedef enum logic [2:0] {
		ST_BALANCED = 3'd0,
		ST_EXTRA    = 3'd1,
		ST_MISMATCH = 3'd2,
		ST_UNCLOSED = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		TK_OTHER   = 3'd0,
		TK_NEWLINE = 3'd1,
		TK_OPEN    = 3'd2,
		TK_CLOSE   = 3'd3,
		TK_END     = 3'd4
	} tok_kind_t;

	typedef enum logic [1:0] {
		BR_PAREN  = 2'd0,
		BR_SQUARE = 2'd1,
		BR_CURLY  = 2'd2
	} br_t;

	typedef struct packed {
		tok_kind_t kind;
		br_t       br;
	} tok_t;

	typedef struct packed {
		logic       op;
		logic [7:0] text_byte;
	} in_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] line_no;
		logic [15:0] col_no;
		logic [7:0]  expected_char;
		logic [7:0]  got_char;
		logic [6:0]  depth;
	} out_t;

	function automatic logic [7:0] closer_of(input br_t b);
		logic [7:0] c;
		case (b)
			BR_PAREN:  c = CH_RPAREN;
			BR_SQUARE: c = CH_RSQUARE;
			BR_CURLY:  c = CH_RCURLY;
			default:   c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> design/bbc_ram.sv
// ----------------------------------------------------------------------------
// bbc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbc_ram #(
	parameter int unsigned WIDTH = 2,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

>>> design/bbc_front.sv
// ----------------------------------------------------------------------------
// bbc_front
// Accepts input transactions and turns each byte into a bracket token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbc_front
	import bbc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      tok_valid,
	input  wire logic tok_ready,
	output tok_t      tok_data
);

	tok_t tok_s1;
	logic valid_s1;
	tok_t tok_c;

	always_comb begin
		tok_c.kind = TK_OTHER;
		tok_c.br = BR_PAREN;
		if (in_data.op == OP_END) begin
			tok_c.kind = TK_END;
		end else begin
			case (in_data.text_byte)
				CH_NEWLINE: tok_c.kind = TK_NEWLINE;
				CH_LPAREN: begin
					tok_c.kind = TK_OPEN;
					tok_c.br = BR_PAREN;
				end
				CH_LSQUARE: begin
					tok_c.kind = TK_OPEN;
					tok_c.br = BR_SQUARE;
				end
				CH_LCURLY: begin
					tok_c.kind = TK_OPEN;
					tok_c.br = BR_CURLY;
				end
				CH_RPAREN: begin
					tok_c.kind = TK_CLOSE;
					tok_c.br = BR_PAREN;
				end
				CH_RSQUARE: begin
					tok_c.kind = TK_CLOSE;
					tok_c.br = BR_SQUARE;
				end
				CH_RCURLY: begin
					tok_c.kind = TK_CLOSE;
					tok_c.br = BR_CURLY;
				end
				default: tok_c.kind = TK_OTHER;
			endcase
		end
	end

	assign in_ready = !valid_s1 || tok_ready;
	assign tok_valid = valid_s1;
	assign tok_data = tok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tok_s1 <= tok_c;
		end
	end

endmodule

`default_nettype wire

>>> design/bbc_queue.sv
// ----------------------------------------------------------------------------
// bbc_queue
// Short token queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbc_queue
	import bbc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic      wr_ready,
	input  wire tok_t wr_data,
	output logic      rd_valid,
	input  wire logic rd_ready,
	output tok_t      rd_data
);

	localparam int unsigned IW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	tok_t          entries_q [QUEUE_DEPTH];
	logic [IW-1:0] wr_ptr_q;
	logic [IW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign wr_ready = (count_q != CW'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data = entries_q[rd_ptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

>>> design/bbc_back.sv
// ----------------------------------------------------------------------------
// bbc_back
// Executes bracket tokens: position tracking, the bracket stack and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bbc_back
	import bbc_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic tok_valid,
	output logic      tok_ready,
	input  wire tok_t tok_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	localparam int unsigned IW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_d;
	logic [CW-1:0] cnt_dec;
	logic [15:0]   line_q;
	logic [15:0]   line_d;
	logic [15:0]   col_q;
	logic [15:0]   col_d;
	logic [15:0]   lline_q;
	logic [15:0]   lline_d;
	logic [15:0]   lcol_q;
	logic [15:0]   lcol_d;
	logic          err_q;
	logic          err_d;
	logic [15:0]   col_inc;
	logic [15:0]   line_inc;

	logic          take;
	logic          res_valid;
	out_t          res;
	out_t          out_q;
	logic          out_valid_q;

	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [1:0]    wr_data;
	logic [IW-1:0] rd_addr;
	logic [1:0]    rd_data;
	logic          fwd_q;
	logic [1:0]    fwd_data_q;
	br_t           top;

	// The RAM is always read at the entry that will be on top after this
	// transaction, so the top is ready on the next cycle. A push writes the
	// very entry being read, and that value is forwarded instead.
	bbc_ram #(
		.WIDTH(2),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign top = br_t'(fwd_q ? fwd_data_q : rd_data);
	assign tok_ready = !out_valid_q || out_ready;
	assign take = tok_valid && tok_ready;
	assign cnt_dec = cnt_q - CW'(1);
	assign col_inc = (col_q == POS_MAX) ? col_q : col_q + 16'd1;
	assign line_inc = (line_q == POS_MAX) ? line_q : line_q + 16'd1;
	assign rd_addr = IW'(cnt_d - CW'(1));

	always_comb begin
		cnt_d = cnt_q;
		line_d = line_q;
		col_d = col_q;
		lline_d = lline_q;
		lcol_d = lcol_q;
		err_d = err_q;
		res_valid = 1'b0;
		res = '0;
		wr_en = 1'b0;
		wr_addr = IW'(cnt_q);
		wr_data = tok_data.br;
		if (take) begin
			if (tok_data.kind == TK_END) begin
				if (!err_q) begin
					res_valid = 1'b1;
					if (cnt_q != '0) begin
						res.status = ST_UNCLOSED;
						res.line_no = lline_q;
						res.col_no = lcol_q;
						res.expected_char = closer_of(top);
						res.depth = 7'(cnt_dec);
					end else begin
						res.status = ST_BALANCED;
					end
				end
				cnt_d = '0;
				line_d = 16'd1;
				col_d = '0;
				lline_d = 16'd1;
				lcol_d = '0;
				err_d = 1'b0;
			end else if (!err_q) begin
				case (tok_data.kind)
					TK_NEWLINE: begin
						line_d = line_inc;
						col_d = '0;
					end
					TK_OPEN: begin
						col_d = col_inc;
						lline_d = line_q;
						lcol_d = col_inc;
						if (cnt_q == CW'(STACK_DEPTH)) begin
							res_valid = 1'b1;
							res.status = ST_OVERFLOW;
							res.line_no = line_q;
							res.col_no = col_inc;
							res.depth = 7'(cnt_q);
							err_d = 1'b1;
						end else begin
							wr_en = 1'b1;
							cnt_d = cnt_q + CW'(1);
						end
					end
					TK_CLOSE: begin
						col_d = col_inc;
						lline_d = line_q;
						lcol_d = col_inc;
						if (cnt_q == '0) begin
							res_valid = 1'b1;
							res.status = ST_EXTRA;
							res.line_no = line_q;
							res.col_no = col_inc;
							res.got_char = closer_of(tok_data.br);
							err_d = 1'b1;
						end else begin
							cnt_d = cnt_dec;
							if (top != tok_data.br) begin
								res_valid = 1'b1;
								res.status = ST_MISMATCH;
								res.line_no = line_q;
								res.col_no = col_inc;
								res.expected_char = closer_of(top);
								res.got_char = closer_of(tok_data.br);
								res.depth = 7'(cnt_dec);
								err_d = 1'b1;
							end
						end
					end
					default: col_d = col_inc;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			line_q <= 16'd1;
			col_q <= '0;
			lline_q <= 16'd1;
			lcol_q <= '0;
			err_q <= 1'b0;
			fwd_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			line_q <= line_d;
			col_q <= col_d;
			lline_q <= lline_d;
			lcol_q <= lcol_d;
			err_q <= err_d;
			fwd_q <= wr_en && (wr_addr == rd_addr);
			if (take && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wr_data;
		if (take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`BBC_ASSERT(a_cnt_bound, cnt_q <= CW'(STACK_DEPTH), "stack count beyond stack depth")
	`BBC_ASSERT_NEXT(a_err_freeze, err_q && !(take && tok_data.kind == TK_END), $stable(cnt_q), "stack moved after an error")
	`BBC_ASSERT_SAME(a_err_reported, $rose(err_q), $past(take && res_valid), "error raised without a result")
	`BBC_ASSERT_NEXT(a_end_clears, take && tok_data.kind == TK_END, cnt_q == '0 && !err_q, "end of text left state behind")

endmodule

`default_nettype wire

>>> design/bracket_balance_checker.sv
// Bracket balance checker.
// Text enters one byte per input transaction (op = 0); a transaction with
// op = 1 marks the end of the text. Results leave on the output channel:
// the first extra closer, mismatch or stack overflow is reported as soon as
// its bracket is seen, and the end of text reports balanced or unclosed
// unless an error has already been reported. After an error, bytes are
// skipped until the end of text, which always clears the checker.
// Both channels use valid/ready. One byte is taken every cycle while in_ready
// is high; on its way to a result a byte passes the classifying front register
// and then the token queue, and the stack stage loads its output register from
// the token at the head of the queue.
// The stack top is read from the stack RAM ahead of the next token, so pushes
// and pops run back to back at one per cycle while no result waits on out_ready.
// A short token queue sits between front and back: when the receiver holds
// out_ready low, the queue fills and in_ready then drops; nothing is lost.
// Reset puts the checker at line 1, column 0 with an empty stack; the stack
// RAM itself needs no clearing.
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Top level: front classifier, token queue and stack back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bracket_balance_checker
	import bbc_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	logic front_valid;
	logic front_ready;
	tok_t front_tok;
	logic back_valid;
	logic back_ready;
	tok_t back_tok;

	bbc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.tok_valid(front_valid),
		.tok_ready(front_ready),
		.tok_data (front_tok)
	);

	bbc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(front_valid),
		.wr_ready(front_ready),
		.wr_data (front_tok),
		.rd_valid(back_valid),
		.rd_ready(back_ready),
		.rd_data (back_tok)
	);

	bbc_back #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok_valid(back_valid),
		.tok_ready(back_ready),
		.tok_data (back_tok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

`default_nettype wire
